@@ hdl/event_fragment_unpacker_top_defines.svh @@
// Assertion macros shared by the RTL files.
`ifndef EVENT_FRAGMENT_UNPACKER_TOP_DEFINES_SVH
`define EVENT_FRAGMENT_UNPACKER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// Check a property on every rising clock edge outside reset.
`define EVFU_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed: %m");

// Check a property on every rising clock edge, reset included.
`define EVFU_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("assertion failed: %m");

`else

`define EVFU_ASSERT(name, clk, rst, prop)
`define EVFU_ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

@@ hdl/evfu_pkg.sv @@
`default_nettype none

package evfu_pkg;

   localparam int unsigned MAX_EVENT_WORDS_DEF = 32768;

   localparam int unsigned WordW  = 16;
   localparam int unsigned PosW   = 16;
   localparam int unsigned EndW   = 17;
   localparam int unsigned LinkW  = 5;
   localparam int unsigned StartW = 15;
   localparam int unsigned NLinks = 32;

   // Result kinds
   localparam logic KIND_FRAGMENT = 1'b0;
   localparam logic KIND_SUMMARY  = 1'b1;

   typedef struct packed {
      logic                kind;
      logic [LinkW-1:0]    link;
      logic [StartW-1:0]   frag_start;
      logic [WordW-1:0]    frag_len;
      logic [WordW-1:0]    event_number;
      logic [WordW-1:0]    status_word;
      logic [NLinks-1:0]   link_mask;
      logic                error;
      logic                last;
   } rsp_type;

   // Results of one accepted word: count is 0, 1 or 2.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } parse_out_type;

endpackage

`default_nettype wire

@@ hdl/evfu_parser.sv @@
`default_nettype none

`include "event_fragment_unpacker_top_defines.svh"

module evfu_parser #(
   parameter int unsigned MAX_EVENT_WORDS = evfu_pkg::MAX_EVENT_WORDS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire logic [evfu_pkg::WordW-1:0]    data_word,
   input  wire logic [evfu_pkg::WordW-1:0]    event_words,
   output evfu_pkg::parse_out_type            parse_out
);

   localparam logic [evfu_pkg::EndW-1:0] MaxWords = evfu_pkg::EndW'(MAX_EVENT_WORDS);

   logic [evfu_pkg::PosW-1:0]   word_pos_ff,   word_pos_in;
   logic [evfu_pkg::EndW-1:0]   next_hdr_ff,   next_hdr_in;
   logic [evfu_pkg::EndW-1:0]   frag_end_ff,   frag_end_in;
   logic [evfu_pkg::PosW-1:0]   frag_start_ff, frag_start_in;
   logic [evfu_pkg::WordW-1:0]  frag_len_ff,   frag_len_in;
   logic                        in_frag_ff,    in_frag_in;
   logic                        stopped_ff,    stopped_in;
   logic [evfu_pkg::NLinks-1:0] seen_ff,       seen_in;
   logic [evfu_pkg::WordW-1:0]  held_num_ff,   held_num_in;
   logic                        dup_ff,        dup_in;

   logic [evfu_pkg::EndW-1:0]   count_clamp;
   logic [evfu_pkg::EndW-1:0]   pos_ext;
   logic                        is_last;
   logic                        desc_valid;
   logic [evfu_pkg::LinkW-1:0]  link_num;
   evfu_pkg::rsp_type           desc;
   evfu_pkg::rsp_type           summary;

   assign count_clamp = ({1'b0, event_words} > MaxWords) ? MaxWords : {1'b0, event_words};
   assign pos_ext     = {1'b0, word_pos_ff};
   assign is_last     = (pos_ext + evfu_pkg::EndW'(1)) >= count_clamp;
   assign link_num    = data_word[evfu_pkg::LinkW-1:0];

   always_comb begin
      logic [evfu_pkg::EndW-1:0] end_pos;

      end_pos       = pos_ext + {1'b0, data_word};
      word_pos_in   = word_pos_ff;
      next_hdr_in   = next_hdr_ff;
      frag_end_in   = frag_end_ff;
      frag_start_in = frag_start_ff;
      frag_len_in   = frag_len_ff;
      in_frag_in    = in_frag_ff;
      stopped_in    = stopped_ff;
      seen_in       = seen_ff;
      held_num_in   = held_num_ff;
      dup_in        = dup_ff;
      desc_valid    = 1'b0;

      if (word_pos_ff == '0) begin
         held_num_in = data_word;
      end else if (!stopped_ff) begin
         if (!in_frag_ff && pos_ext == next_hdr_ff) begin
            if (end_pos >= count_clamp) begin
               stopped_in = 1'b1;
            end else begin
               frag_start_in = word_pos_ff;
               frag_len_in   = data_word;
               frag_end_in   = end_pos;
               in_frag_in    = 1'b1;
            end
         end
         // zero-length fragment closes on its own length word
         if (in_frag_in && pos_ext == frag_end_in) begin
            in_frag_in  = 1'b0;
            next_hdr_in = frag_end_in + evfu_pkg::EndW'(1);
            if (seen_ff[link_num]) begin
               dup_in     = 1'b1;
               stopped_in = 1'b1;
            end else begin
               seen_in    = seen_ff | (evfu_pkg::NLinks'(1) << link_num);
               desc_valid = 1'b1;
            end
         end
      end

      desc              = '0;
      desc.kind         = evfu_pkg::KIND_FRAGMENT;
      desc.link         = link_num;
      desc.frag_start   = frag_start_in[evfu_pkg::StartW-1:0];
      desc.frag_len     = frag_len_in;
      desc.last         = !is_last;

      summary              = '0;
      summary.kind         = evfu_pkg::KIND_SUMMARY;
      summary.event_number = held_num_in;
      summary.status_word  = data_word;
      summary.link_mask    = seen_in;
      summary.error        = dup_in;
      summary.last         = 1'b1;

      if (is_last) begin
         word_pos_in   = '0;
         next_hdr_in   = evfu_pkg::EndW'(1);
         frag_end_in   = '0;
         frag_start_in = '0;
         frag_len_in   = '0;
         in_frag_in    = 1'b0;
         stopped_in    = 1'b0;
         seen_in       = '0;
         held_num_in   = '0;
         dup_in        = 1'b0;
      end else begin
         word_pos_in = word_pos_ff + evfu_pkg::PosW'(1);
      end

      parse_out = '0;
      if (accept) begin
         if (desc_valid) begin
            parse_out.first  = desc;
            parse_out.second = summary;
            parse_out.count  = is_last ? 2'd2 : 2'd1;
         end else begin
            parse_out.first = summary;
            parse_out.count = is_last ? 2'd1 : 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_pos_ff   <= '0;
         next_hdr_ff   <= evfu_pkg::EndW'(1);
         frag_end_ff   <= '0;
         frag_start_ff <= '0;
         frag_len_ff   <= '0;
         in_frag_ff    <= 1'b0;
         stopped_ff    <= 1'b0;
         seen_ff       <= '0;
         held_num_ff   <= '0;
         dup_ff        <= 1'b0;
      end else if (accept) begin
         word_pos_ff   <= word_pos_in;
         next_hdr_ff   <= next_hdr_in;
         frag_end_ff   <= frag_end_in;
         frag_start_ff <= frag_start_in;
         frag_len_ff   <= frag_len_in;
         in_frag_ff    <= in_frag_in;
         stopped_ff    <= stopped_in;
         seen_ff       <= seen_in;
         held_num_ff   <= held_num_in;
         dup_ff        <= dup_in;
      end
   end

   `EVFU_ASSERT(a_reset_after_summary, clock, reset, (accept && is_last) |=> (word_pos_ff == '0 && seen_ff == '0))
   `EVFU_ASSERT(a_open_frag_ends_ahead, clock, reset, in_frag_ff |-> (frag_end_ff > {1'b0, frag_start_ff}))
   `EVFU_ASSERT(a_open_frag_not_stopped, clock, reset, in_frag_ff |-> !stopped_ff)
   `EVFU_ASSERT(a_second_is_summary, clock, reset, (parse_out.count == 2'd2) |-> (parse_out.second.kind == evfu_pkg::KIND_SUMMARY))

endmodule

`default_nettype wire

@@ hdl/evfu_rsp_queue.sv @@
`default_nettype none

`include "event_fragment_unpacker_top_defines.svh"

module evfu_rsp_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire evfu_pkg::parse_out_type parse_out,
   output logic                      full,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output evfu_pkg::rsp_type         rsp_head
);

   // Three entries, always read at entry zero; new results land behind the fill.
   localparam int unsigned Depth = 3;

   evfu_pkg::rsp_type q_ff [Depth];
   evfu_pkg::rsp_type q_in [Depth];
   logic [1:0]        count_ff, count_in;
   logic              pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign pop       = rsp_valid && !rsp_stall;
   // room for two results is needed before a word is taken
   assign full      = (count_ff >= 2'd2);
   assign rsp_head  = q_ff[0];

   always_comb begin
      logic [1:0] base;

      base = count_ff;
      for (int i = 0; i < Depth; i++) begin
         q_in[i] = q_ff[i];
      end
      if (pop) begin
         for (int i = 0; i < Depth - 1; i++) begin
            q_in[i] = q_ff[i + 1];
         end
         base = count_ff - 2'd1;
      end
      for (int i = 0; i < Depth; i++) begin
         if (parse_out.count != 2'd0 && 2'(i) == base) begin
            q_in[i] = parse_out.first;
         end else if (parse_out.count == 2'd2 && 2'(i) == base + 2'd1) begin
            q_in[i] = parse_out.second;
         end
      end
      count_in = base + parse_out.count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      for (int i = 0; i < Depth; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

   `EVFU_ASSERT(a_no_overflow, clock, reset, (parse_out.count != 2'd0) |-> (count_ff <= 2'd1))
   `EVFU_ASSERT(a_drain_to_empty, clock, reset, (pop && count_ff == 2'd1 && parse_out.count == 2'd0) |=> !rsp_valid)
   `EVFU_ASSERT_ALWAYS(a_empty_in_reset, clock, reset |=> (count_ff == 2'd0))

endmodule

`default_nettype wire

@@ hdl/event_fragment_unpacker_top.sv @@
// Event fragment unpacker: takes one 16-bit event word per transfer on req_,
// with the event's word count alongside, and returns fragment descriptors and
// a closing event summary on rsp_. A word is taken every clock while req_stall
// is low; its results go into a three-entry result queue, so a word is taken
// while earlier results still wait. The queue holds req_stall high while it
// has two or more entries. With the receiver always ready that happens only
// after the last word of an event also closes a fragment (two results), and
// the following word then waits for a pop; a stalling receiver fills it sooner.
`default_nettype none

module event_fragment_unpacker_top #(
   parameter int unsigned MAX_EVENT_WORDS = evfu_pkg::MAX_EVENT_WORDS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [evfu_pkg::WordW-1:0]     req_data_word,
   input  wire logic [evfu_pkg::WordW-1:0]     req_event_words,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic                                rsp_kind,
   output logic [evfu_pkg::LinkW-1:0]          rsp_link,
   output logic [evfu_pkg::StartW-1:0]         rsp_frag_start,
   output logic [evfu_pkg::WordW-1:0]          rsp_frag_len,
   output logic [evfu_pkg::WordW-1:0]          rsp_event_number,
   output logic [evfu_pkg::WordW-1:0]          rsp_status_word,
   output logic [evfu_pkg::NLinks-1:0]         rsp_link_mask,
   output logic                                rsp_error,
   output logic                                rsp_last
);

   evfu_pkg::parse_out_type parse_out;
   evfu_pkg::rsp_type       rsp_head;
   logic                    full;
   logic                    accept;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   evfu_parser #(
      .MAX_EVENT_WORDS (MAX_EVENT_WORDS)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .data_word   (req_data_word),
      .event_words (req_event_words),
      .parse_out   (parse_out)
   );

   evfu_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .parse_out (parse_out),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_head  (rsp_head)
   );

   assign rsp_kind         = rsp_head.kind;
   assign rsp_link         = rsp_head.link;
   assign rsp_frag_start   = rsp_head.frag_start;
   assign rsp_frag_len     = rsp_head.frag_len;
   assign rsp_event_number = rsp_head.event_number;
   assign rsp_status_word  = rsp_head.status_word;
   assign rsp_link_mask    = rsp_head.link_mask;
   assign rsp_error        = rsp_head.error;
   assign rsp_last         = rsp_head.last;

endmodule

`default_nettype wire

@@ bench/event_fragment_unpacker_top_tb.sv @@
`timescale 1ns / 100ps

module event_fragment_unpacker_top_tb;

   localparam int QUIET_LIMIT = 2000;
   localparam int MAX_REPORTS = 10;
   localparam logic [16:0] EVT_WORDS_CAP = 17'(evfu_pkg::MAX_EVENT_WORDS_DEF);

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_data_word = '0;
   logic [15:0] req_event_words = '0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_kind;
   logic [4:0]  rsp_link;
   logic [14:0] rsp_frag_start;
   logic [15:0] rsp_frag_len;
   logic [15:0] rsp_event_number;
   logic [15:0] rsp_status_word;
   logic [31:0] rsp_link_mask;
   logic        rsp_error;
   logic        rsp_last;

   // idle knobs, in percent of cycles
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_left = 0;

   int words_sent = 0;
   int error_count = 0;
   int quiet_cycles = 0;

   evfu_pkg::rsp_type pending_results[$];
   logic [15:0] ev_words[$];

   // unpacker state as predicted
   logic [15:0] pos_q;
   logic [16:0] hdr_pos;
   logic [16:0] frag_end;
   logic [15:0] frag_start;
   logic [15:0] frag_len;
   logic        in_frag;
   logic        stopped;
   logic [31:0] links_seen;
   logic [15:0] evt_num;
   logic        dup_err;

   event_fragment_unpacker_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_word    (req_data_word),
      .req_event_words  (req_event_words),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_link         (rsp_link),
      .rsp_frag_start   (rsp_frag_start),
      .rsp_frag_len     (rsp_frag_len),
      .rsp_event_number (rsp_event_number),
      .rsp_status_word  (rsp_status_word),
      .rsp_link_mask    (rsp_link_mask),
      .rsp_error        (rsp_error),
      .rsp_last         (rsp_last)
   );

   always #2 clock = ~clock;

   function void clear_unpack_state();
      pos_q      = '0;
      hdr_pos    = 17'd1;
      frag_end   = '0;
      frag_start = '0;
      frag_len   = '0;
      in_frag    = 1'b0;
      stopped    = 1'b0;
      links_seen = '0;
      evt_num    = '0;
      dup_err    = 1'b0;
   endfunction

   // Advance the unpacker state by one accepted word and queue its results.
   function void unpack_word(input logic [15:0] w, input logic [15:0] cnt_in);
      logic [16:0] cnt;
      logic [16:0] end_pos;
      logic        is_last;
      logic        have_desc;
      evfu_pkg::rsp_type r;
      cnt = ({1'b0, cnt_in} > EVT_WORDS_CAP) ? EVT_WORDS_CAP : {1'b0, cnt_in};
      is_last = ({1'b0, pos_q} + 17'd1 >= cnt);
      have_desc = 1'b0;
      if (pos_q == 0) begin
         evt_num = w;
      end else if (!stopped) begin
         if (!in_frag && {1'b0, pos_q} == hdr_pos) begin
            end_pos = {1'b0, pos_q} + {1'b0, w};
            if (end_pos >= cnt) begin
               stopped = 1'b1;
            end else begin
               frag_start = pos_q;
               frag_len   = w;
               frag_end   = end_pos;
               in_frag    = 1'b1;
            end
         end
         if (in_frag && {1'b0, pos_q} == frag_end) begin
            in_frag = 1'b0;
            hdr_pos = frag_end + 17'd1;
            if (links_seen[w[4:0]]) begin
               dup_err = 1'b1;
               stopped = 1'b1;
            end else begin
               links_seen[w[4:0]] = 1'b1;
               have_desc = 1'b1;
            end
         end
      end
      if (have_desc) begin
         r = '0;
         r.kind       = evfu_pkg::KIND_FRAGMENT;
         r.link       = w[4:0];
         r.frag_start = frag_start[14:0];
         r.frag_len   = frag_len;
         r.last       = !is_last;
         pending_results.push_back(r);
      end
      if (is_last) begin
         r = '0;
         r.kind         = evfu_pkg::KIND_SUMMARY;
         r.event_number = evt_num;
         r.status_word  = w;
         r.link_mask    = links_seen;
         r.error        = dup_err;
         r.last         = 1'b1;
         pending_results.push_back(r);
         clear_unpack_state();
      end else begin
         pos_q = pos_q + 16'd1;
      end
   endfunction

   function string fmt_rsp(input evfu_pkg::rsp_type r);
      return $sformatf({"kind=%0d link=%0d start=%0d len=%h evt=%h status=%h",
                        " mask=%h err=%0d last=%0d"},
                       r.kind, r.link, r.frag_start, r.frag_len, r.event_number,
                       r.status_word, r.link_mask, r.error, r.last);
   endfunction

   task automatic report_error(input string msg);
      if (error_count < MAX_REPORTS) $display("%0t ERROR %s", $realtime, msg);
      error_count++;
   endtask

   // Starts and ends at a falling edge; valid stays high for a back-to-back word.
   task automatic send_word(input logic [15:0] w, input logic [15:0] cnt);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_data_word   <= w;
      req_event_words <= cnt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      unpack_word(w, cnt);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic send_event(input logic [15:0] cnt);
      foreach (ev_words[i]) send_word(ev_words[i], cnt);
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   // Well-formed event with random fragments; sometimes a repeated link,
   // the status word doubling as a link word, or a truncated word count.
   task automatic build_event(output logic [15:0] cnt);
      int n_frag;
      int len;
      int cut;
      logic [4:0]  lnk;
      logic [31:0] used;
      ev_words.delete();
      used = '0;
      ev_words.push_back(16'($urandom));
      n_frag = $urandom_range(0, 8);
      for (int f = 0; f < n_frag; f++) begin
         lnk = 5'($urandom);
         if (used != '0 && $urandom_range(0, 11) == 0) begin
            while (!used[lnk]) lnk = 5'($urandom);
         end else if (used != '1) begin
            while (used[lnk]) lnk = lnk + 5'd1;
         end
         used[lnk] = 1'b1;
         len = ($urandom_range(0, 15) == 0) ? $urandom_range(6, 40) : $urandom_range(1, 5);
         if (lnk == 5'd0 && $urandom_range(0, 1) == 1) begin
            ev_words.push_back(16'h0000);
         end else begin
            ev_words.push_back(16'(len));
            repeat (len - 1) ev_words.push_back(16'($urandom));
            ev_words.push_back({11'($urandom), lnk});
         end
      end
      if (n_frag == 0 || $urandom_range(0, 5) != 0) ev_words.push_back(16'($urandom));
      cnt = 16'(ev_words.size());
      if ($urandom_range(0, 7) == 0) begin
         cut = $urandom_range(1, ev_words.size());
         while (ev_words.size() > cut) void'(ev_words.pop_back());
         cnt = 16'(cut);
      end
   endtask

   // Random words with random counts, closed by a word that must end the event.
   task automatic send_noise();
      int n;
      logic [15:0] cnt;
      n = $urandom_range(1, 6);
      repeat (n) begin
         case ($urandom_range(0, 2))
            0: cnt = 16'($urandom);
            1: cnt = 16'($urandom_range(32769, 65535));
            default: cnt = 16'($urandom_range(0, 12));
         endcase
         send_word(16'($urandom), cnt);
      end
      send_word(16'($urandom), 16'($urandom_range(0, 1)));
   endtask

   task automatic test_tiny_events();
      send_word(16'hFFFF, 16'd0);
      send_word(16'h0000, 16'd1);
   endtask

   task automatic test_fragment_shapes();
      // zero-length fragment on link 0, then link 31
      ev_words = '{16'h1234, 16'h0000, 16'h0002, 16'hAAAA, 16'hFFFF, 16'h8001};
      send_event(16'd6);
      // link word is also the status word
      ev_words = '{16'h00FF, 16'h0001, 16'hFFE7};
      send_event(16'd3);
      // fragment runs past the event end
      ev_words = '{16'h0F0F, 16'hFFFF, 16'h5A5A};
      send_event(16'd3);
   endtask

   task automatic test_duplicate_link();
      ev_words = '{16'h5555, 16'h0001, 16'h0018, 16'h0001, 16'h0038, 16'h7777, 16'h0000};
      send_event(16'd7);
   endtask

   task automatic test_count_override();
      send_word(16'hABCD, 16'hFFFF);
      send_word(16'h0003, 16'h8001);
      send_word(16'h1111, 16'h8000);
      send_word(16'h2222, 16'd3);
   endtask

   task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                      input int n_words);
      int start;
      logic [15:0] cnt;
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      start = words_sent;
      while (words_sent - start < n_words) begin
         if ($urandom_range(0, 9) < 8) begin
            build_event(cnt);
            send_event(cnt);
         end else begin
            send_noise();
         end
      end
      wait_results_drained();
   endtask

   // One descriptor every other word while the receiver holds off for a
   // long stretch: the result queue fills and the input stalls.
   task automatic test_receiver_hold();
      ev_words.delete();
      ev_words.push_back(16'($urandom));
      for (int l = 0; l < 32; l++) begin
         ev_words.push_back(16'h0001);
         ev_words.push_back({11'($urandom), 5'(l)});
      end
      ev_words.push_back(16'($urandom));
      hold_left = 300;
      send_event(16'(ev_words.size()));
      wait_results_drained();
   endtask

   task automatic test_pause_for_drain();
      logic [15:0] cnt;
      repeat (2) begin
         build_event(cnt);
         send_event(cnt);
      end
      wait_results_drained();
      @(negedge clock);
      build_event(cnt);
      send_event(cnt);
      wait_results_drained();
   endtask

   // receiver side
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      evfu_pkg::rsp_type got;
      evfu_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.kind         = rsp_kind;
         got.link         = rsp_link;
         got.frag_start   = rsp_frag_start;
         got.frag_len     = rsp_frag_len;
         got.event_number = rsp_event_number;
         got.status_word  = rsp_status_word;
         got.link_mask    = rsp_link_mask;
         got.error        = rsp_error;
         got.last         = rsp_last;
         if (pending_results.size() == 0) begin
            report_error({"result with nothing expected: ", fmt_rsp(got)});
         end else begin
            want = pending_results.pop_front();
            if (got !== want)
               report_error({"mismatch\n  exp: ", fmt_rsp(want), "\n  got: ", fmt_rsp(got)});
         end
      end
   end

   // watchdog: cycles with no transfer on either channel
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
               $display("%0t timeout, %0d results outstanding", $realtime,
                        pending_results.size());
               $display("event_fragment_unpacker_top_tb: errors");
               $finish;
            end
         end
      end
   end

   initial begin
      clear_unpack_state();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 15;
      recv_idle_pct = 76;
      test_tiny_events();
      test_fragment_shapes();
      test_duplicate_link();
      test_count_override();
      wait_results_drained();

      test_random_traffic(15, 76, 430);
      test_receiver_hold();
      test_random_traffic(76, 15, 430);
      test_pause_for_drain();
      test_random_traffic(0, 0, 430);

      wait_results_drained();
      repeat (20) @(posedge clock);
      if (pending_results.size() != 0)
         report_error($sformatf("%0d expected results never arrived",
                                pending_results.size()));
      if (error_count == 0) begin
         $display("event_fragment_unpacker_top_tb: clean");
      end else begin
         $display("event_fragment_unpacker_top_tb: errors");
      end
      $finish;
   end

endmodule
